// ===== rtl/msru_pkg.sv =====
// Package for the machine state register unit: beat types, command codes
// and MSR bit positions (big-endian numbering mapped to vector indexes).
// No dependencies.
`timescale 1ns / 1ps

package msru_pkg;

    // Command codes carried in the command field
    typedef enum logic [2:0] {
        CMD_MOVE_FULL = 3'd0,
        CMD_MOVE_D_L0 = 3'd1,
        CMD_MOVE_D_L1 = 3'd2,
        CMD_RETURN    = 3'd3,
        CMD_READ      = 3'd4
    } cmd_code_t;

    // Input beat
    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] operand;
        logic [63:0] return_address;
        logic [63:0] saved_state;
    } cmd_beat_t;

    // Result beat
    typedef struct packed {
        logic [63:0] state_value;
        logic [63:0] branch_target;
        logic        branch_taken;
    } rsp_beat_t;

    // Big-endian bit n of the MSR sits at vector index 63 - n
    localparam int MSR_SF = 63 - 0;
    localparam int MSR_HV = 63 - 3;
    localparam int MSR_EE = 63 - 48;
    localparam int MSR_PR = 63 - 49;
    localparam int MSR_ME = 63 - 51;
    localparam int MSR_IR = 63 - 58;
    localparam int MSR_DR = 63 - 59;
    localparam int MSR_RI = 63 - 62;

    // Mask of big-endian bits first..last, evaluated at elaboration
    function automatic logic [63:0] be_range(input int first, input int last);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (i >= first && i <= last)
                m[63 - i] = 1'b1;
        end
        return m;
    endfunction

    // Bits copied straight from the saved state on return from interrupt
    localparam logic [63:0] RFID_COPY_MASK =
        be_range(1, 2) | be_range(4, 32) | be_range(37, 41) |
        be_range(49, 50) | be_range(52, 57) | be_range(60, 63);

endpackage

// ===== rtl/machine_state_register_unit.sv =====
// Top level of the machine state register unit: input register, MSR,
// result register. Depends on msru_pkg and msru_alu.
//
//  channel | valid     | ready     | payload               | beat moves when
//  --------+-----------+-----------+-----------------------+----------------------
//  command | cmd_valid | cmd_ready | cmd (cmd_beat_t)      | cmd_valid & cmd_ready
//  result  | rsp_valid | rsp_ready | rsp (rsp_beat_t)      | rsp_valid & rsp_ready
//
// One beat per cycle sustained while rsp_ready is high. A command beat
// goes through the input register, then the result register, which loads
// with the MSR. The MSR resets to zero and both stages reset empty.
// When rsp_ready is low, the input register still takes one more beat,
// then cmd_ready drops until the result drains.
`timescale 1ns / 1ps

module machine_state_register_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  msru_pkg::cmd_beat_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output msru_pkg::rsp_beat_t rsp
);
    import msru_pkg::*;

    logic        in_valid_reg;
    cmd_beat_t   in_item_reg;
    logic        rsp_valid_reg;
    rsp_beat_t   rsp_reg;
    logic [63:0] msr_reg;
    logic [63:0] msr_next;
    rsp_beat_t   rsp_next;
    logic        advance;

    // Compute stage moves when the result register is free or draining
    assign advance   = in_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready = !in_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    msru_alu u_alu (
        .msr      (msr_reg),
        .item     (in_item_reg),
        .msr_next (msr_next),
        .result   (rsp_next)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            msr_reg       <= '0;
        end
        else
        begin
            if (cmd_ready)
                in_valid_reg <= cmd_valid;
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                msr_reg       <= msr_next;
            end
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            in_item_reg <= cmd;
        if (advance)
            rsp_reg <= rsp_next;
    end

endmodule

// ===== rtl/msru_alu.sv =====
// Next-state and result logic for the machine state register unit.
// Depends on msru_pkg.
`timescale 1ns / 1ps

module msru_alu (
    input  logic [63:0]        msr,
    input  msru_pkg::cmd_beat_t item,
    output logic [63:0]        msr_next,
    output msru_pkg::rsp_beat_t result
);
    import msru_pkg::*;

    logic [63:0] mv_l0;
    logic [63:0] mv_l1;
    logic [63:0] rfid;
    logic [63:0] target;
    logic [63:0] op;
    logic [63:0] srr1;

    assign op   = item.operand;
    assign srr1 = item.saved_state;

    // Doubleword move, L=0: HV and ME kept, SF/EE/IR/DR forced from ORs
    always_comb
    begin
        mv_l0         = op;
        mv_l0[MSR_HV] = msr[MSR_HV];
        mv_l0[MSR_ME] = msr[MSR_ME];
        mv_l0[MSR_SF] = op[MSR_SF] | op[63 - 1];
        mv_l0[MSR_EE] = op[MSR_EE] | op[MSR_PR];
        mv_l0[MSR_IR] = op[MSR_IR] | op[MSR_PR];
        mv_l0[MSR_DR] = op[MSR_DR] | op[MSR_PR];
    end

    // Doubleword move, L=1: only EE and RI change
    always_comb
    begin
        mv_l1         = msr;
        mv_l1[MSR_EE] = op[MSR_EE];
        mv_l1[MSR_RI] = op[MSR_RI];
    end

    // Return from interrupt: rebuild MSR from saved state and current HV and ME
    always_comb
    begin
        rfid          = srr1 & RFID_COPY_MASK;
        rfid[MSR_SF]  = srr1[MSR_SF] | srr1[63 - 1];
        rfid[MSR_HV]  = msr[MSR_HV] & srr1[MSR_HV];
        rfid[MSR_ME]  = msr[MSR_HV] ? srr1[MSR_ME] : msr[MSR_ME];
        rfid[MSR_EE]  = srr1[MSR_EE];
        rfid[MSR_IR]  = srr1[MSR_IR] | srr1[MSR_PR];
        rfid[MSR_DR]  = srr1[MSR_DR] | srr1[MSR_PR];
    end

    // Branch target: word aligned, 32-bit when the new SF is clear
    always_comb
    begin
        target       = {item.return_address[63:2], 2'b00};
        if (!rfid[MSR_SF])
            target[63:32] = '0;
    end

    // Command select
    always_comb
    begin
        msr_next             = msr;
        result.branch_target = '0;
        result.branch_taken  = 1'b0;
        case (cmd_code_t'(item.command))
            CMD_MOVE_FULL: msr_next = op;
            CMD_MOVE_D_L0: msr_next = mv_l0;
            CMD_MOVE_D_L1: msr_next = mv_l1;
            CMD_RETURN:
            begin
                msr_next             = rfid;
                result.branch_target = target;
                result.branch_taken  = 1'b1;
            end
            default:       msr_next = msr;
        endcase
        result.state_value = msr_next;
    end

endmodule

// ===== rtl/msru_checker.sv =====
// Port-level checks for the machine state register unit, bound to the top.
// Depends on msru_pkg and machine_state_register_unit.
`timescale 1ns / 1ps

module msru_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_ready,
    input  msru_pkg::cmd_beat_t cmd,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  msru_pkg::rsp_beat_t rsp
);
    import msru_pkg::*;

    // A stalled command beat holds
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("command beat changed while stalled");

    // A stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // Only a return from interrupt carries a branch target
    a_no_target: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.branch_taken |-> rsp.branch_target == 64'd0)
        else $error("branch target without a return");

    // Branch target is word aligned
    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.branch_taken |-> rsp.branch_target[1:0] == 2'b00)
        else $error("branch target not word aligned");

    // 32-bit mode target has a clear upper word
    a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.branch_taken && !rsp.state_value[MSR_SF]
        |-> rsp.branch_target[63:32] == 32'd0)
        else $error("32-bit branch target has upper bits set");

endmodule

bind machine_state_register_unit msru_checker u_msru_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
